FILE: rtl/core/tdc_code_density_calibrator_top_assert.svh
`ifndef TDC_CODE_DENSITY_CALIBRATOR_TOP_ASSERT_SVH
`define TDC_CODE_DENSITY_CALIBRATOR_TOP_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define TDCCAL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tdccal assertion failed");

// next-cycle implication
`define TDCCAL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tdccal assertion failed");

`endif

FILE: rtl/core/tdccal_pkg.sv
package tdccal_pkg;

	localparam int NUM_TDC      = 4;
	localparam int NUM_CHANNELS = 33;
	localparam int FINE_BINS    = 1024;
	localparam int FRAC_BITS    = 12;

	localparam int NUM_CELLS  = NUM_TDC * NUM_CHANNELS;
	localparam int HIST_DEPTH = NUM_CELLS * FINE_BINS;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int CELL_AW    = $clog2(NUM_CELLS);
	localparam int FINE_AW    = $clog2(FINE_BINS);

	localparam int CORR_DEPTH   = 64;
	localparam int CORR_AW      = 6;
	localparam int CORR_PER_TDC = 16;

	localparam int NS_PER_TICK  = 5;
	localparam int NS_PER_EPOCH = 10240;
	localparam int LIN_HALF     = 512;
	localparam int FULL_SPAN    = NS_PER_TICK << FRAC_BITS;
	localparam int FT_W         = $clog2(FULL_SPAN + 1);

	localparam int SUM_W  = 32 + $clog2(FINE_BINS);
	localparam int DEN_W  = SUM_W + 1;
	localparam int REM_W  = DEN_W + 1;
	localparam int DVD_W  = DEN_W + 3 + FRAC_BITS;
	localparam int DIV_CW = $clog2(FT_W);

	localparam int TIME_W = 55;
	localparam logic [15:0] MIN_ENTRIES_RESET = 16'd100;

	localparam int CLR_LEN = (HIST_DEPTH > CORR_DEPTH) ? HIST_DEPTH : CORR_DEPTH;
	localparam int CLR_W   = $clog2(CLR_LEN + 1);

	localparam logic [1:0] REQ_HIT  = 2'd0;
	localparam logic [1:0] REQ_CAL  = 2'd1;
	localparam logic [1:0] REQ_CORR = 2'd2;
	localparam logic [1:0] REQ_ALL  = 2'd3;

	typedef struct packed {
		logic clr_step;
		logic latch;
		logic hit_rd;
		logic hit_wb;
		logic bin_clr;
		logic sum_clr;
		logic sum_rd;
		logic bin_inc;
		logic cum_clr;
		logic tab_ld;
		logic div_step;
		logic tab_wr;
		logic set_done;
		logic cfg_exec;
		logic out_load;
		logic out_hit;
		logic out_status;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_in;
		logic       clr_last;
		logic       bin_last;
		logic       div_last;
		logic       cal_ok;
		logic       sum_zero;
	} sts_t;

	// linear fine time, the fine-table content until a channel is calibrated
	function automatic logic [FT_W-1:0] lin_fine(input logic [FINE_AW-1:0] f);
		longint v;
		v = longint'(FULL_SPAN);
		if (longint'(f) < longint'(LIN_HALF))
			v = ((longint'(NS_PER_TICK) * (longint'(f) + 1)) << FRAC_BITS) / LIN_HALF;
		if (v > longint'(FULL_SPAN))
			v = longint'(FULL_SPAN);
		return FT_W'(v);
	endfunction

endpackage

FILE: rtl/core/tdccal_ram.sv
module tdccal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/tdccal_ctrl.sv
`include "tdc_code_density_calibrator_top_assert.svh"

module tdccal_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tdccal_pkg::sts_t  sts,
	output tdccal_pkg::cmd_t  cmd
);

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_CLEAR    = 14'b00000000000010,
		S_HIT_RD   = 14'b00000000000100,
		S_HIT_WB   = 14'b00000000001000,
		S_CAL_RD   = 14'b00000000010000,
		S_CAL_CHK  = 14'b00000000100000,
		S_SUM_RUN  = 14'b00000001000000,
		S_SUM_TAIL = 14'b00000010000000,
		S_SUM_CHK  = 14'b00000100000000,
		S_TAB_RD   = 14'b00001000000000,
		S_TAB_LD   = 14'b00010000000000,
		S_TAB_DIV  = 14'b00100000000000,
		S_TAB_WR   = 14'b01000000000000,
		S_CFG      = 14'b10000000000000
	} state_t;

	state_t state_q, state_nx;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last)
					state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					if (sts.req_in == tdccal_pkg::REQ_HIT)
						state_nx = S_HIT_RD;
					else if (sts.req_in == tdccal_pkg::REQ_CAL)
						state_nx = S_CAL_RD;
					else
						state_nx = S_CFG;
				end
			end
			S_HIT_RD: begin
				cmd.hit_rd = 1'b1;
				state_nx   = S_HIT_WB;
			end
			S_HIT_WB: begin
				cmd.hit_wb   = 1'b1;
				cmd.out_load = 1'b1;
				cmd.out_hit  = 1'b1;
				state_nx     = S_IDLE;
			end
			S_CAL_RD: begin
				cmd.bin_clr = 1'b1;
				cmd.sum_clr = 1'b1;
				state_nx    = S_CAL_CHK;
			end
			S_CAL_CHK: begin
				if (!sts.cal_ok) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = 1'b1;
					state_nx       = S_IDLE;
				end else begin
					state_nx = S_SUM_RUN;
				end
			end
			S_SUM_RUN: begin
				cmd.sum_rd  = 1'b1;
				cmd.bin_inc = 1'b1;
				if (sts.bin_last)
					state_nx = S_SUM_TAIL;
			end
			S_SUM_TAIL: begin
				state_nx = S_SUM_CHK;
			end
			S_SUM_CHK: begin
				if (sts.sum_zero) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = 1'b1;
					state_nx       = S_IDLE;
				end else begin
					cmd.cum_clr = 1'b1;
					state_nx    = S_TAB_RD;
				end
			end
			S_TAB_RD: begin
				state_nx = S_TAB_LD;
			end
			S_TAB_LD: begin
				cmd.tab_ld = 1'b1;
				state_nx   = S_TAB_DIV;
			end
			S_TAB_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_nx = S_TAB_WR;
			end
			S_TAB_WR: begin
				cmd.tab_wr  = 1'b1;
				cmd.bin_inc = 1'b1;
				if (sts.bin_last) begin
					cmd.set_done = 1'b1;
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end else begin
					state_nx = S_TAB_RD;
				end
			end
			S_CFG: begin
				cmd.cfg_exec = 1'b1;
				cmd.out_load = 1'b1;
				state_nx     = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_nx;
	end

	`TDCCAL_ASSERT_NEXT(a_out_then_idle, cmd.out_load, state_q == S_IDLE)
	`TDCCAL_ASSERT_NOW(a_no_out_in_clear, state_q == S_CLEAR, !cmd.out_load && !start || !cmd.latch)
	`TDCCAL_ASSERT_NEXT(a_div_to_write, state_q == S_TAB_DIV && sts.div_last, state_q == S_TAB_WR)
	`TDCCAL_ASSERT_NEXT(a_accept_leaves_idle, cmd.latch,
		state_q == S_HIT_RD || state_q == S_CAL_RD || state_q == S_CFG)

endmodule

FILE: rtl/core/tdccal_dp.sv
module tdccal_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tdccal_pkg::cmd_t                cmd,
	output tdccal_pkg::sts_t                sts,
	input  logic                            cfg_we,
	input  logic [15:0]                     cfg_data,
	input  logic [1:0]                      req_type,
	input  logic [1:0]                      tdc_index,
	input  logic [5:0]                      channel,
	input  logic [27:0]                     epoch,
	input  logic [10:0]                     coarse,
	input  logic [9:0]                      fine,
	input  logic [5:0]                      corr_index,
	input  logic signed [31:0]              corr_value,
	output logic                            result_valid,
	output logic signed [tdccal_pkg::TIME_W-1:0] full_time,
	output logic                            status,
	output logic                            calibrated
);

	localparam int HAW = tdccal_pkg::HIST_AW;
	localparam int TW  = tdccal_pkg::TIME_W;
	localparam int FTW = tdccal_pkg::FT_W;

	logic [15:0] min_entries_q;
	logic [1:0]  req_q;
	logic        valid_q, cnt_ok_q, use_corr_q;
	logic [tdccal_pkg::CELL_AW-1:0] cell_q;
	logic [HAW-1:0] base_q;
	logic [tdccal_pkg::CORR_AW-1:0] cidx_q, ci_q;
	logic [31:0] cv_q;
	logic [27:0] epoch_q;
	logic [10:0] coarse_q;
	logic [9:0]  fine_q;
	logic [TW-1:0] tbase_s1;

	logic [tdccal_pkg::CLR_W-1:0]   clr_q;
	logic [tdccal_pkg::FINE_AW-1:0] bin_q;
	logic all_done_q;
	logic [tdccal_pkg::SUM_W-1:0] sum_q, cum_q;
	logic sum_v_s1;
	logic [tdccal_pkg::DEN_W-1:0] den_q;
	logic [tdccal_pkg::REM_W-1:0] rem_q;
	logic [FTW-1:0] dvd_lo_q, quo_q;
	logic [tdccal_pkg::DIV_CW-1:0] div_cnt_q;

	logic result_valid_q, status_q, calibrated_q;
	logic [TW-1:0] full_time_q;

	// memory ports
	logic [HAW-1:0] hist_ra, hist_wa, ft_wa;
	logic hist_we, ft_we, hits_we, corr_we, done_we;
	logic [31:0] hist_wd, hist_rd, hits_wd, hits_rd, corr_wd, corr_rd;
	logic [FTW-1:0] ft_wd, ft_rd;
	logic [tdccal_pkg::CELL_AW-1:0] hits_wa, done_wa;
	logic [tdccal_pkg::CORR_AW-1:0] corr_wa;
	logic done_wd, done_rd;

	logic in_clr_hist, in_clr_hits, in_clr_corr;
	logic in_valid;
	logic [tdccal_pkg::CELL_AW-1:0] in_cell;
	logic [7:0] in_cidx;
	logic [tdccal_pkg::DEN_W-1:0] num;
	logic [tdccal_pkg::DVD_W-1:0] dvd;
	logic [tdccal_pkg::REM_W-1:0] trial;
	logic [TW-1:0] t_hit, ft_sub, corr_sub;
	logic hit_done;

	// request decode
	assign in_valid = (32'(tdc_index) < tdccal_pkg::NUM_TDC)
		&& (32'(channel) < tdccal_pkg::NUM_CHANNELS);
	assign in_cell = in_valid
		? tdccal_pkg::CELL_AW'(32'(tdc_index) * tdccal_pkg::NUM_CHANNELS + 32'(channel))
		: '0;
	assign in_cidx = 8'(8'(tdc_index) * 8'(tdccal_pkg::CORR_PER_TDC))
		+ 8'((channel - 6'd1) >> 1);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q      <= req_type;
			valid_q    <= in_valid;
			cnt_ok_q   <= in_valid && (32'(fine) < tdccal_pkg::FINE_BINS);
			use_corr_q <= in_valid && (channel != 6'd0);
			cell_q     <= in_cell;
			base_q     <= HAW'(32'(in_cell) * tdccal_pkg::FINE_BINS);
			cidx_q     <= in_cidx[tdccal_pkg::CORR_AW-1:0];
			ci_q       <= corr_index;
			cv_q       <= corr_value;
			epoch_q    <= epoch;
			coarse_q   <= coarse;
			fine_q     <= fine;
		end
		if (cmd.hit_rd)
			tbase_s1 <= TW'(42'(epoch_q) * 42'(tdccal_pkg::NS_PER_EPOCH)
				+ 42'(coarse_q) * 42'(tdccal_pkg::NS_PER_TICK)) << tdccal_pkg::FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			min_entries_q <= tdccal_pkg::MIN_ENTRIES_RESET;
		else if (cfg_we)
			min_entries_q <= cfg_data;
	end

	// clearing sweep and bin counter
	assign in_clr_hist = 32'(clr_q) < tdccal_pkg::HIST_DEPTH;
	assign in_clr_hits = 32'(clr_q) < tdccal_pkg::NUM_CELLS;
	assign in_clr_corr = 32'(clr_q) < tdccal_pkg::CORR_DEPTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			bin_q <= '0;
		end else begin
			if (cmd.clr_step)
				clr_q <= clr_q + 1'b1;
			if (cmd.bin_clr)
				bin_q <= '0;
			else if (cmd.clr_step || cmd.bin_inc)
				bin_q <= sts.bin_last ? '0 : bin_q + 1'b1;
		end
	end

	// memory hookup
	assign hist_ra = base_q + (cmd.hit_rd ? HAW'(fine_q) : HAW'(bin_q));

	always_comb begin
		hist_we = 1'b0;
		hist_wa = base_q + HAW'(fine_q);
		hist_wd = (hist_rd == 32'hFFFF_FFFF) ? hist_rd : hist_rd + 32'd1;
		ft_we   = 1'b0;
		ft_wa   = base_q + HAW'(bin_q);
		ft_wd   = quo_q;
		hits_we = 1'b0;
		hits_wa = cell_q;
		hits_wd = (hits_rd == 32'hFFFF_FFFF) ? hits_rd : hits_rd + 32'd1;
		corr_we = 1'b0;
		corr_wa = ci_q;
		corr_wd = cv_q;
		done_we = 1'b0;
		done_wa = cell_q;
		done_wd = 1'b1;
		if (cmd.clr_step) begin
			hist_we = in_clr_hist;
			hist_wa = clr_q[HAW-1:0];
			hist_wd = '0;
			ft_we   = in_clr_hist;
			ft_wa   = clr_q[HAW-1:0];
			ft_wd   = tdccal_pkg::lin_fine(bin_q);
			hits_we = in_clr_hits;
			hits_wa = clr_q[tdccal_pkg::CELL_AW-1:0];
			hits_wd = '0;
			corr_we = in_clr_corr;
			corr_wa = clr_q[tdccal_pkg::CORR_AW-1:0];
			corr_wd = '0;
			done_we = in_clr_hits;
			done_wa = clr_q[tdccal_pkg::CELL_AW-1:0];
			done_wd = 1'b0;
		end else begin
			if (cmd.hit_wb) begin
				hist_we = cnt_ok_q;
				hits_we = cnt_ok_q;
			end
			if (cmd.tab_wr)
				ft_we = 1'b1;
			if (cmd.cfg_exec && req_q == tdccal_pkg::REQ_CORR)
				corr_we = 1'b1;
			if (cmd.set_done)
				done_we = 1'b1;
		end
	end

	tdccal_ram #(.WIDTH(32), .DEPTH(tdccal_pkg::HIST_DEPTH)) u_hist (
		.clk(clk), .we(hist_we), .waddr(hist_wa), .wdata(hist_wd),
		.raddr(hist_ra), .rdata(hist_rd));

	tdccal_ram #(.WIDTH(FTW), .DEPTH(tdccal_pkg::HIST_DEPTH)) u_ftab (
		.clk(clk), .we(ft_we), .waddr(ft_wa), .wdata(ft_wd),
		.raddr(hist_ra), .rdata(ft_rd));

	tdccal_ram #(.WIDTH(32), .DEPTH(tdccal_pkg::NUM_CELLS)) u_hits (
		.clk(clk), .we(hits_we), .waddr(hits_wa), .wdata(hits_wd),
		.raddr(cell_q), .rdata(hits_rd));

	tdccal_ram #(.WIDTH(32), .DEPTH(tdccal_pkg::CORR_DEPTH)) u_corr (
		.clk(clk), .we(corr_we), .waddr(corr_wa), .wdata(corr_wd),
		.raddr(cidx_q), .rdata(corr_rd));

	tdccal_ram #(.WIDTH(1), .DEPTH(tdccal_pkg::NUM_CELLS)) u_done (
		.clk(clk), .we(done_we), .waddr(done_wa), .wdata(done_wd),
		.raddr(cell_q), .rdata(done_rd));

	// histogram sum, then one long division per bin
	assign num   = (tdccal_pkg::DEN_W'(cum_q) << 1) + tdccal_pkg::DEN_W'(hist_rd);
	assign dvd   = ((tdccal_pkg::DVD_W'(num) << 2) + tdccal_pkg::DVD_W'(num))
		<< tdccal_pkg::FRAC_BITS;
	assign trial = {rem_q[tdccal_pkg::REM_W-2:0], dvd_lo_q[FTW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sum_v_s1 <= 1'b0;
		else
			sum_v_s1 <= cmd.sum_rd;
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_clr)
			sum_q <= '0;
		else if (sum_v_s1)
			sum_q <= sum_q + tdccal_pkg::SUM_W'(hist_rd);
		if (cmd.cum_clr) begin
			cum_q <= '0;
			den_q <= {sum_q, 1'b0};
		end else if (cmd.tab_ld) begin
			cum_q <= cum_q + tdccal_pkg::SUM_W'(hist_rd);
		end
		if (cmd.tab_ld) begin
			rem_q     <= tdccal_pkg::REM_W'(dvd >> FTW);
			dvd_lo_q  <= dvd[FTW-1:0];
			quo_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_lo_q  <= dvd_lo_q << 1;
			div_cnt_q <= div_cnt_q + 1'b1;
			if (trial >= tdccal_pkg::REM_W'(den_q)) begin
				rem_q <= trial - tdccal_pkg::REM_W'(den_q);
				quo_q <= {quo_q[FTW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[FTW-2:0], 1'b0};
			end
		end
	end

	// mark-all flag, per-channel flags live in u_done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			all_done_q <= 1'b0;
		else if (cmd.cfg_exec && req_q == tdccal_pkg::REQ_ALL)
			all_done_q <= 1'b1;
	end

	// hit time
	assign hit_done = cnt_ok_q && (all_done_q || done_rd);
	assign ft_sub   = hit_done ? TW'(ft_rd) : '0;
	assign corr_sub = use_corr_q ? {{(TW-32){corr_rd[31]}}, corr_rd} : '0;
	assign t_hit    = tbase_s1 - ft_sub - corr_sub;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else
			result_valid_q <= cmd.out_load;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			full_time_q  <= cmd.out_hit ? t_hit : '0;
			calibrated_q <= cmd.out_hit && hit_done;
			status_q     <= cmd.out_status;
		end
	end

	assign result_valid = result_valid_q;
	assign full_time    = full_time_q;
	assign status       = status_q;
	assign calibrated   = calibrated_q;

	always_comb begin
		sts.req_in   = req_type;
		sts.clr_last = (32'(clr_q) == tdccal_pkg::CLR_LEN - 1);
		sts.bin_last = (32'(bin_q) == tdccal_pkg::FINE_BINS - 1);
		sts.div_last = (32'(div_cnt_q) == tdccal_pkg::FT_W - 1);
		sts.cal_ok   = valid_q && (hits_rd >= 32'(min_entries_q));
		sts.sum_zero = (sum_q == '0);
	end

endmodule

FILE: rtl/core/tdc_code_density_calibrator_top.sv
// TDC fine-time calibrator by code density.
// Requests enter on start when busy is low; one result item comes back for
// every request, shown for one cycle with result_valid. The receiver cannot
// hold results off, so nothing waits on it.
// Hit (req_type 0): the block reads in HIT_RD, writes back in HIT_WB and
// registers the result; busy is already low in that result cycle.
// Calibrate (req_type 1): one pass summing FINE_BINS histogram bins, then a
// second pass with a bit-serial divider for each bin. Refused calibrations
// return from the CAL_CHK state, for a bad channel or fewer than min_entries
// hits, or after the sum pass if it is empty.
// Correction write and mark-all (req_type 2, 3): result from the S_CFG state.
// The histogram and fine-table memories share one read address.
// Configuration: min_entries is written on cfg_valid with cfg_ready high;
// the user must write it only while the block is idle, which is not enforced.
// After reset the block sweeps its memories, one address a cycle, over
// NUM_TDC*NUM_CHANNELS*FINE_BINS addresses (135168), with busy high:
// histograms, hit counts and calibrated flags to zero, fine tables to linear,
// corrections zero.
module tdc_code_density_calibrator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data,
	input  logic [1:0]          req_type,
	input  logic [1:0]          tdc_index,
	input  logic [5:0]          channel,
	input  logic [27:0]         epoch,
	input  logic [10:0]         coarse,
	input  logic [9:0]          fine,
	input  logic [5:0]          corr_index,
	input  logic signed [31:0]  corr_value,
	output logic                result_valid,
	output logic signed [54:0]  full_time,
	output logic                status,
	output logic                calibrated
);

	tdccal_pkg::cmd_t cmd;
	tdccal_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	tdccal_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sts(sts), .cmd(cmd));

	tdccal_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_valid && cfg_ready), .cfg_data(cfg_data),
		.req_type(req_type), .tdc_index(tdc_index), .channel(channel),
		.epoch(epoch), .coarse(coarse), .fine(fine),
		.corr_index(corr_index), .corr_value(corr_value),
		.result_valid(result_valid), .full_time(full_time),
		.status(status), .calibrated(calibrated));

endmodule
